// ----- rtl/line_crc_check_char_encoder_core_assert.svh -----
// assertion helpers for the rtl file that checks its own logic
`ifndef LINE_CRC_CHECK_CHAR_ENCODER_CORE_ASSERT_SVH
`define LINE_CRC_CHECK_CHAR_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define LCCE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lcce assertion failed");

// next-cycle implication, checked on every rising edge out of reset
`define LCCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lcce assertion failed");

`endif

// ----- rtl/lcce_pkg.sv -----
package lcce_pkg;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] LOW_MASK  = 16'h7fff;
    // 216 = 8 * 27; the odd factor is divided through a scaled reciprocal
    localparam logic [11:0] RECIP_27  = 12'd2427;
    localparam logic [5:0]  RADIX_ODD = 6'd27;

    // crc word handed from the crc stage to the character stage
    typedef struct packed {
        logic        valid;
        logic [15:0] crc;
    } crc_req_t;

    // remainder of h << 16 under the polynomial
    function automatic logic [15:0] crc_table_entry(input logic [7:0] h);
        logic [15:0] r;
        r = {h, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    // digit 0..215 to printable symbol, skipping 0x2a, 0x7f, 0x91 and 0x93
    function automatic logic [7:0] code_symbol(input logic [7:0] d);
        logic [7:0] s;
        if (d < 8'd9) begin
            s = d + 8'h21;
        end else if (d < 8'd93) begin
            s = d + 8'h22;
        end else if (d < 8'd110) begin
            s = d + 8'h23;
        end else if (d == 8'd110) begin
            s = 8'h92;
        end else begin
            s = d + 8'h25;
        end
        return s;
    endfunction

endpackage

// ----- rtl/line_crc_check_char_encoder_core.sv -----
// crc-16 (poly 0x1021, augmented form) check character encoder
//
// input channel s_*: one message byte per request, s_last_byte marks the
// final byte. the accumulator starts at zero and returns to zero after the
// final byte, so the next byte opens a new message.
// result channel m_*: one request per message, carrying the full crc and
// three printable check characters (low and high base-216 digits of the
// crc masked to 15 bits, and the mini digit of the full crc).
// throughput: one byte per cycle while s_ready is high, the crc update on
// the accumulator register being combinational.
// the final crc is registered in the crc stage, then divided, encoded and
// registered again in the divide and symbol stage.
// reset (aresetn low, synchronous) clears the accumulator and both valids.
// when the receiver stalls, each stage holds one request; bytes not marked
// last are taken as long as the crc stage can advance, and the input
// stalls once both stages hold a result.
module line_crc_check_char_encoder_core import lcce_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_crc_value,
    output logic [7:0]  m_low_check_char,
    output logic [7:0]  m_high_check_char,
    output logic [7:0]  m_mini_check_char
);

    crc_req_t crc_req;
    logic     char_take;

    lcce_crc_stage u_crc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .take        (char_take),
        .req         (crc_req)
    );

    lcce_char_stage u_char (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .req               (crc_req),
        .take              (char_take),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_crc_value       (m_crc_value),
        .m_low_check_char  (m_low_check_char),
        .m_high_check_char (m_high_check_char),
        .m_mini_check_char (m_mini_check_char)
    );

`include "line_crc_check_char_encoder_core_assert.svh"

    // a final byte always yields a crc request in the next cycle
    `LCCE_ASSERT_NEXT(a_last_to_crc, s_valid && s_ready && s_last_byte, crc_req.valid)
    // a blocked crc request keeps its word
    `LCCE_ASSERT_NEXT(a_crc_hold, crc_req.valid && !char_take,
        crc_req.valid && $stable(crc_req.crc))
    // a crc request taken by the character stage shows up on the output
    `LCCE_ASSERT_NEXT(a_crc_to_out, crc_req.valid && char_take, m_valid)

endmodule

// ----- rtl/lcce_crc_stage.sv -----
module lcce_crc_stage import lcce_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    input  logic       take,
    output crc_req_t   req
);

    logic [15:0] acc_reg, acc_next;
    logic        crc_valid_reg, crc_valid_next;
    logic [15:0] crc_word_reg, crc_word_next;
    logic [15:0] crc_calc;
    logic        accept;

    assign s_ready  = !crc_valid_reg || take;
    assign accept   = s_valid && s_ready;
    assign crc_calc = crc_table_entry(acc_reg[15:8]) ^ {acc_reg[7:0], s_data_byte};

    always_comb begin
        acc_next       = acc_reg;
        crc_valid_next = crc_valid_reg;
        crc_word_next  = crc_word_reg;
        if (s_ready) begin
            crc_valid_next = s_valid && s_last_byte;
        end
        if (accept) begin
            // end of message restarts the accumulator
            acc_next = s_last_byte ? 16'h0000 : crc_calc;
            if (s_last_byte) begin
                crc_word_next = crc_calc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= 16'h0000;
            crc_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            crc_valid_reg <= crc_valid_next;
        end
        crc_word_reg <= crc_word_next;
    end

    assign req.valid = crc_valid_reg;
    assign req.crc   = crc_word_reg;

endmodule

// ----- rtl/lcce_div216.sv -----
module lcce_div216 import lcce_pkg::*; (
    input  logic [15:0] value,
    output logic [8:0]  quo,
    output logic [7:0]  rem
);

    logic [12:0] y;
    logic [24:0] prod;
    logic [8:0]  q_est;
    logic [12:0] q_times;
    logic [12:0] r_est;

    // value / 216 = (value >> 3) / 27, low three bits go to the remainder
    assign y     = value[15:3];
    assign prod  = {12'd0, y} * {13'd0, RECIP_27};
    assign q_est = prod[24:16];
    // q * 27 as shifts and adds
    assign q_times = {q_est, 4'b0000} + {1'b0, q_est, 3'b000}
                   + {3'b000, q_est, 1'b0} + {4'b0000, q_est};
    assign r_est = y - q_times;

    // estimate is exact or one short
    always_comb begin
        if (r_est >= {7'd0, RADIX_ODD}) begin
            quo = q_est + 9'd1;
            rem = {r_est[4:0] - RADIX_ODD[4:0], value[2:0]};
        end else begin
            quo = q_est;
            rem = {r_est[4:0], value[2:0]};
        end
    end

endmodule

// ----- rtl/lcce_char_stage.sv -----
module lcce_char_stage import lcce_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  crc_req_t    req,
    output logic        take,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_crc_value,
    output logic [7:0]  m_low_check_char,
    output logic [7:0]  m_high_check_char,
    output logic [7:0]  m_mini_check_char
);

    logic        m_valid_reg, m_valid_next;
    logic [15:0] crc_reg;
    logic [7:0]  low_reg, high_reg, mini_reg;
    logic [15:0] low_part;
    logic [8:0]  low_quo, full_quo;
    logic [7:0]  low_rem, full_rem;
    logic        load;

    assign take     = !m_valid_reg || m_ready;
    assign load     = take && req.valid;
    assign low_part = req.crc & LOW_MASK;

    lcce_div216 u_div_low (
        .value (low_part),
        .quo   (low_quo),
        .rem   (low_rem)
    );

    lcce_div216 u_div_full (
        .value (req.crc),
        .quo   (full_quo),
        .rem   (full_rem)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = req.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (load) begin
            crc_reg  <= req.crc;
            low_reg  <= code_symbol(low_rem);
            // masked quotient stays below 216
            high_reg <= code_symbol(low_quo[7:0]);
            mini_reg <= code_symbol(full_rem);
        end
    end

    // full quotient is not part of the result
    logic unused_quo;
    assign unused_quo = ^{full_quo, low_quo[8]};

    assign m_valid           = m_valid_reg;
    assign m_crc_value       = crc_reg;
    assign m_low_check_char  = low_reg;
    assign m_high_check_char = high_reg;
    assign m_mini_check_char = mini_reg;

endmodule

// ----- tb/testbench.sv -----
module testbench;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int ITEM_TARGET = 950;

    class crc_scoreboard;
        typedef struct {
            bit [15:0] crc;
            bit [7:0]  low_char;
            bit [7:0]  high_char;
            bit [7:0]  mini_char;
        } check_word_t;

        bit [15:0]   crc_lut [256];
        bit [15:0]   running_crc;
        check_word_t pending_words[$];
        int          mismatch_count;

        function new();
            bit [15:0] r;
            for (int h = 0; h < 256; h++) begin
                r = 16'(h << 8);
                repeat (8) begin
                    r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
                end
                crc_lut[h] = r;
            end
            running_crc    = '0;
            mismatch_count = 0;
        endfunction

        // each step skips one more hole in the printable range
        function bit [7:0] symbol_of(int unsigned digit);
            int unsigned s;
            s = 'h21 + digit;
            if (digit >= 9)   s++;
            if (digit >= 93)  s++;
            if (digit >= 110) s++;
            if (digit >= 111) s++;
            return s[7:0];
        endfunction

        function void note_byte(bit [7:0] data, bit last);
            bit [15:0]   c;
            bit [15:0]   masked;
            check_word_t w;
            c = crc_lut[running_crc[15:8]] ^ {running_crc[7:0], data};
            if (!last) begin
                running_crc = c;
                return;
            end
            masked      = c & 16'h7fff;
            w.crc       = c;
            w.low_char  = symbol_of(masked % 216);
            w.high_char = symbol_of(masked / 216);
            w.mini_char = symbol_of(c % 216);
            pending_words.push_back(w);
            running_crc = '0;
        endfunction

        function void check_result(bit [15:0] crc, bit [7:0] lo, bit [7:0] hi, bit [7:0] mini);
            check_word_t w;
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: crc %h chars %h %h %h", crc, lo, hi, mini);
                return;
            end
            w = pending_words.pop_front();
            if (w.crc !== crc || w.low_char !== lo || w.high_char !== hi ||
                w.mini_char !== mini) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: want crc %h lo %h hi %h mini %h, got %h %h %h %h",
                             w.crc, w.low_char, w.high_char, w.mini_char,
                             crc, lo, hi, mini);
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_crc_value;
    logic [7:0]  m_low_check_char;
    logic [7:0]  m_high_check_char;
    logic [7:0]  m_mini_check_char;

    crc_scoreboard sb = new();
    int  bytes_sent = 0;
    bit  quiet_phase = 1'b0;
    bit  hold_request = 1'b0;
    int  stall_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    line_crc_check_char_encoder_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_crc_value       (m_crc_value),
        .m_low_check_char  (m_low_check_char),
        .m_high_check_char (m_high_check_char),
        .m_mini_check_char (m_mini_check_char)
    );

    // receiver: random stalls, one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                m_ready      <= 1'b0;
            end else if (quiet_phase) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 14);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_crc_value, m_low_check_char, m_high_check_char,
                            m_mini_check_char);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_byte(input bit [7:0] data, input bit last);
        if (!quiet_phase && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 30);
        end
        s_valid     <= 1'b1;
        s_data_byte <= data;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(data, last);
        bytes_sent++;
        if (bytes_sent == 300)
            hold_request = 1'b1;
        quiet_phase = (bytes_sent >= 600 && bytes_sent < 760);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
    endtask

    initial begin
        bit [8:0] directed_items[$];
        int  roll;
        // {last, data}: one-byte messages at the extremes, then short runs
        directed_items = '{
            9'h100, 9'h1ff, 9'h180, 9'h101, 9'h17f,
            9'h0ff, 9'h0ff, 9'h1ff,
            9'h000, 9'h000, 9'h100,
            9'h012, 9'h034, 9'h056, 9'h178,
            9'h0aa, 9'h055, 9'h0f0, 9'h10f,
            9'h031, 9'h032, 9'h133
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_items[i])
            send_byte(directed_items[i][7:0], directed_items[i][8]);
        // wait out every result before the random part
        drain_results();
        @(posedge aclk);

        while (bytes_sent < ITEM_TARGET) begin
            roll = $urandom_range(99);
            if (roll < 85)
                send_message($urandom_range(1, 8));
            else if (roll < 95)
                send_message($urandom_range(9, 24));
            else
                send_message($urandom_range(25, 64));
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- line_crc_check_char_encoder_core.f -----
+incdir+rtl
rtl/lcce_pkg.sv
rtl/lcce_crc_stage.sv
rtl/lcce_div216.sv
rtl/lcce_char_stage.sv
rtl/line_crc_check_char_encoder_core.sv
tb/testbench.sv
